// ===== hw/rtl/point_in_polygon_winding_defines.svh =====
// Assertion helpers for the RTL.
`ifndef POINT_IN_POLYGON_WINDING_DEFINES_SVH
`define POINT_IN_POLYGON_WINDING_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define PIPW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PIPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pipw_pkg.sv =====
package pipw_pkg;

  localparam int COORD_W          = 16;
  localparam int WIND_W           = 12;
  localparam int MIN_VERTICES     = 3;
  localparam int MAX_VERTICES_DEF = 1024;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WIND_W-1:0]  wind_t;

  typedef struct packed {
    logic up;
    logic down;
  } edge_vote_t;

  localparam wind_t WIND_MAX = {1'b0, {(WIND_W-1){1'b1}}};
  localparam wind_t WIND_MIN = {1'b1, {(WIND_W-1){1'b0}}};
  localparam wind_t WIND_ONE = {{(WIND_W-1){1'b0}}, 1'b1};

  // Apply one edge vote to the running count, saturating at both ends.
  function automatic wind_t wind_step(wind_t w, edge_vote_t v);
    wind_t r;
    r = w;
    if (v.up && (w != WIND_MAX)) begin
      r = w + WIND_ONE;
    end else if (v.down && (w != WIND_MIN)) begin
      r = w - WIND_ONE;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/point_in_polygon_winding.sv =====
// Winding-number point-in-polygon test over a stream of polygon vertices.
// Input channel (in_*): one item per vertex, carrying the query point and the
// vertex; in_last_vertex closes the polygon. The query point is taken from the
// first item of each polygon only. An item is taken when in_valid is high and
// in_stall is low.
// Result channel (out_*): one item per polygon, issued for its last vertex:
// out_inside_res, out_winding_number and out_bad_polygon. A polygon with fewer
// than 3 or more than MAX_VERTICES vertices gives out_bad_polygon = 1 with the
// other two fields zero. The count saturates at the ends of its 12-bit range.
// Throughput: one vertex per cycle while in_stall is low. A last vertex passes
// through the input register, then its result is written to the result register
// and shown on out_*. Both edge tests and the count update are combinational
// logic between the input register and the result register.
// Stall: a waiting result holds in the result register while out_stall is high;
// non-final vertices keep flowing, and in_stall rises only when a final vertex
// waits on a full result register. Reset (rst_n low, synchronous) empties both
// registers and returns to the start of a polygon.
`include "point_in_polygon_winding_defines.svh"

module point_in_polygon_winding import pipw_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  coord_t             in_query_x,
  input  coord_t             in_query_y,
  input  coord_t             in_vertex_x,
  input  coord_t             in_vertex_y,
  input  logic               in_last_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_inside_res,
  output logic [WIND_W-1:0]  out_winding_number,
  output logic               out_bad_polygon
);

  // Vertex counter saturates at MAX_VERTICES + 1.
  localparam int SEEN_W = $clog2(MAX_VERTICES + 2);
  localparam logic [SEEN_W-1:0] MAX_SEEN = SEEN_W'(MAX_VERTICES);
  localparam logic [SEEN_W-1:0] MIN_SEEN = SEEN_W'(MIN_VERTICES);
  localparam logic [SEEN_W-1:0] ONE_SEEN = SEEN_W'(1);

  // Input register.
  logic   s1_valid_r, s1_valid_nxt;
  coord_t s1_qx_r, s1_qy_r, s1_vx_r, s1_vy_r;
  logic   s1_last_r;

  // Polygon state.
  coord_t held_x_r, held_y_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  wind_t  wind_r, wind_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt, seen_inc;

  // Result register.
  logic  out_valid_r, out_valid_nxt;
  logic  out_inside_r, out_bad_r;
  wind_t out_wind_r;

  logic       in_accept, s1_adv, s1_emit, is_first, bad_c;
  edge_vote_t vote_open, vote_close;
  wind_t      wind_base, wind_mid, wind_end;

  // Advance the input register unless a final vertex meets a full, stalled
  // result register.
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign s1_emit   = s1_adv && s1_last_r;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign is_first  = (seen_r == '0);

  // Edge from the previous vertex to this one.
  pipw_edge u_edge_open (
    .en   (!is_first),
    .cx   (prev_x_r),
    .cy   (prev_y_r),
    .nx   (s1_vx_r),
    .ny   (s1_vy_r),
    .px   (held_x_r),
    .py   (held_y_r),
    .vote (vote_open)
  );

  // Closing edge from the last vertex back to the first. With a single vertex
  // it is degenerate, so drop it on the first item.
  pipw_edge u_edge_close (
    .en   (!is_first && s1_last_r),
    .cx   (s1_vx_r),
    .cy   (s1_vy_r),
    .nx   (first_x_r),
    .ny   (first_y_r),
    .px   (held_x_r),
    .py   (held_y_r),
    .vote (vote_close)
  );

  assign wind_base = is_first ? '0 : wind_r;
  assign wind_mid  = wind_step(wind_base, vote_open);
  assign wind_end  = wind_step(wind_mid, vote_close);
  assign seen_inc  = (seen_r <= MAX_SEEN) ? (seen_r + ONE_SEEN) : seen_r;
  assign bad_c     = (seen_nxt < MIN_SEEN) || (seen_nxt > MAX_SEEN);

  always_comb begin
    seen_nxt = is_first ? ONE_SEEN : seen_inc;
    wind_nxt = wind_end;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state: handshake flags, vertex count and winding count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      wind_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        // Return to the start of a polygon after its last vertex.
        seen_r <= s1_last_r ? '0 : seen_nxt;
        wind_r <= s1_last_r ? '0 : wind_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_qx_r   <= in_query_x;
      s1_qy_r   <= in_query_y;
      s1_vx_r   <= in_vertex_x;
      s1_vy_r   <= in_vertex_y;
      s1_last_r <= in_last_vertex;
    end
    if (s1_adv) begin
      prev_x_r <= s1_vx_r;
      prev_y_r <= s1_vy_r;
      if (is_first) begin
        held_x_r  <= s1_qx_r;
        held_y_r  <= s1_qy_r;
        first_x_r <= s1_vx_r;
        first_y_r <= s1_vy_r;
      end
    end
    if (s1_emit) begin
      out_bad_r    <= bad_c;
      out_inside_r <= !bad_c && (wind_end != '0);
      out_wind_r   <= bad_c ? '0 : wind_end;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_inside_res     = out_inside_r;
  assign out_winding_number = out_wind_r;
  assign out_bad_polygon    = out_bad_r;

  `PIPW_ASSERT_IMPL(a_bad_clears, out_valid_r && out_bad_r, !out_inside_r && (out_wind_r == '0), "bad polygon result carries a nonzero count or inside flag")
  `PIPW_ASSERT_IMPL(a_inside_match, out_valid_r && !out_bad_r, out_inside_r == (out_wind_r != '0), "inside flag disagrees with winding count")
  `PIPW_ASSERT_NEXT(a_restart, s1_emit, (seen_r == '0) && out_valid_r, "final vertex did not restart the polygon or raise a result")
  `PIPW_ASSERT_IMPL(a_seen_bound, 1'b1, seen_r <= (MAX_SEEN + ONE_SEEN), "vertex counter passed its saturation point")

endmodule

// ===== hw/rtl/pipw_edge.sv =====
module pipw_edge import pipw_pkg::*; (
  input  logic       en,
  input  coord_t     cx,
  input  coord_t     cy,
  input  coord_t     nx,
  input  coord_t     ny,
  input  coord_t     px,
  input  coord_t     py,
  output edge_vote_t vote
);

  localparam int DW = COORD_W + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  logic signed [DW-1:0] dnx_c, dpy_c, dpx_c, dny_c;
  logic signed [PW-1:0] prod_a_c, prod_b_c;
  logic signed [XW-1:0] cross_c;

  // Exact cross product of (n - c) and (p - c).
  assign dnx_c    = DW'(nx) - DW'(cx);
  assign dpy_c    = DW'(py) - DW'(cy);
  assign dpx_c    = DW'(px) - DW'(cx);
  assign dny_c    = DW'(ny) - DW'(cy);
  assign prod_a_c = dnx_c * dpy_c;
  assign prod_b_c = dpx_c * dny_c;
  assign cross_c  = XW'(prod_a_c) - XW'(prod_b_c);

  assign vote.up   = en && (cy <= py) && (ny > py) && !cross_c[XW-1] && (cross_c != '0);
  assign vote.down = en && (cy > py) && (ny <= py) && cross_c[XW-1];

endmodule

// ===== sim/point_in_polygon_winding_tb.sv =====
// Expected result of one closed polygon.
typedef struct {
  logic                        inside_flag;
  logic [pipw_pkg::WIND_W-1:0] wind;
  logic                        bad;
} poly_verdict_t;

// Tracks the polygon being streamed and queues one verdict per closed polygon.
class winding_scoreboard;
  localparam int WIND_TOP  = 2 ** (pipw_pkg::WIND_W - 1) - 1;
  localparam int WIND_BOT  = -(2 ** (pipw_pkg::WIND_W - 1));
  localparam int VERTS_MAX = pipw_pkg::MAX_VERTICES_DEF;
  localparam int VERTS_MIN = pipw_pkg::MIN_VERTICES;

  longint        held_px, held_py;
  longint        first_vx, first_vy;
  longint        prev_vx, prev_vy;
  int            wind_count;
  int unsigned   verts;
  int unsigned   raw_len;
  poly_verdict_t verdicts[$];

  int errors;
  int polygons;
  int bad_polygons;
  int results;
  int unsigned vertex_items;
  int unsigned longest;

  function new();
    held_px = 0; held_py = 0;
    first_vx = 0; first_vy = 0;
    prev_vx = 0; prev_vy = 0;
    wind_count = 0;
    verts = 0;
    raw_len = 0;
    errors = 0;
    polygons = 0;
    bad_polygons = 0;
    results = 0;
    vertex_items = 0;
    longest = 0;
  endfunction

  // Sign of the exact cross product; operands fit easily in 64 bits.
  function int turn_sign(input longint cx, cy, nx, ny);
    longint c;
    c = (nx - cx) * (held_py - cy) - (held_px - cx) * (ny - cy);
    if (c > 0) return 1;
    if (c < 0) return -1;
    return 0;
  endfunction

  function void count_crossing(input longint cx, cy, nx, ny);
    if (cy <= held_py) begin
      if (ny > held_py && turn_sign(cx, cy, nx, ny) > 0 && wind_count < WIND_TOP)
        wind_count++;
    end else begin
      if (ny <= held_py && turn_sign(cx, cy, nx, ny) < 0 && wind_count > WIND_BOT)
        wind_count--;
    end
  endfunction

  function void note_vertex(input pipw_pkg::coord_t qx, qy, vx, vy, input logic last);
    poly_verdict_t v;
    longint        x;
    longint        y;
    x = longint'(vx);
    y = longint'(vy);
    vertex_items++;
    if (verts == 0) begin
      held_px    = longint'(qx);
      held_py    = longint'(qy);
      first_vx   = x;
      first_vy   = y;
      wind_count = 0;
      verts      = 1;
      raw_len    = 1;
    end else begin
      count_crossing(prev_vx, prev_vy, x, y);
      if (verts <= VERTS_MAX) verts++;
      raw_len++;
    end
    prev_vx = x;
    prev_vy = y;
    if (last) begin
      count_crossing(x, y, first_vx, first_vy);
      v.bad = (verts < VERTS_MIN) || (verts > VERTS_MAX);
      if (v.bad) begin
        v.inside_flag = 1'b0;
        v.wind        = '0;
        bad_polygons++;
      end else begin
        v.inside_flag = (wind_count != 0);
        v.wind        = wind_count[pipw_pkg::WIND_W-1:0];
      end
      verdicts.push_back(v);
      polygons++;
      if (raw_len > longest) longest = raw_len;
      verts      = 0;
      wind_count = 0;
    end
  endfunction

  // Cap the printout so a badly broken block cannot flood the log.
  task report(input string what);
    if (errors < 50) $display("ERROR: %s", what);
    errors++;
  endtask

  task check_result(input logic got_inside, input logic [pipw_pkg::WIND_W-1:0] got_wind,
                    input logic got_bad);
    poly_verdict_t want;
    if (verdicts.size() == 0) begin
      report("result arrived with no closed polygon waiting");
      return;
    end
    want = verdicts.pop_front();
    results++;
    if (got_inside !== want.inside_flag)
      report($sformatf("polygon %0d inside flag: got %b want %b",
                       results, got_inside, want.inside_flag));
    if (got_wind !== want.wind)
      report($sformatf("polygon %0d winding number: got %0d want %0d",
                       results, $signed(got_wind), $signed(want.wind)));
    if (got_bad !== want.bad)
      report($sformatf("polygon %0d bad flag: got %b want %b", results, got_bad, want.bad));
  endtask

  function int pending();
    return verdicts.size();
  endfunction
endclass

module point_in_polygon_winding_tb import pipw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     RANDOM_ITEMS   = 600;
  localparam coord_t COORD_LO       = 16'sh8000;
  localparam coord_t COORD_HI       = 16'sh7fff;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  coord_t            in_query_x;
  coord_t            in_query_y;
  coord_t            in_vertex_x;
  coord_t            in_vertex_y;
  logic              in_last_vertex;
  logic              out_valid;
  logic              out_stall;
  logic              out_inside_res;
  logic [WIND_W-1:0] out_winding_number;
  logic              out_bad_polygon;

  winding_scoreboard sb = new();

  // Polygon under construction, streamed by send_polygon.
  coord_t poly_x[$];
  coord_t poly_y[$];

  int unsigned tx_items    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned held_cycles  = 0;

  point_in_polygon_winding uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_query_x        (in_query_x),
    .in_query_y        (in_query_y),
    .in_vertex_x       (in_vertex_x),
    .in_vertex_y       (in_vertex_y),
    .in_last_vertex    (in_last_vertex),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_inside_res    (out_inside_res),
    .out_winding_number(out_winding_number),
    .out_bad_polygon   (out_bad_polygon)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels at the falling edge: everything driven at the rising
  // edge has settled, and the item moves at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_inside_res, out_winding_number, out_bad_polygon);
    if (rst_n && in_valid && in_stall)
      held_cycles <= held_cycles + 1;
  end

  // Watchdog: end the run when neither channel moves an item for too long.
  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("point_in_polygon_winding: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side pacing: random stalls, then a long hold-off that lets the
  // block fill up and push back on its input, then a clean stretch.
  initial begin : rx_pacing
    int unsigned rx_cycle;
    int unsigned phase;
    out_stall = 1'b0;
    rx_cycle  = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      phase = rx_cycle % 700;
      if (phase < 400) begin
        out_stall <= ($urandom_range(99) < 25);
      end else if (phase < 520) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      rx_cycle++;
      @(posedge clk);
    end
  end

  function automatic coord_t clamp_coord(input int v);
    if (v > 32767) return COORD_HI;
    if (v < -32768) return COORD_LO;
    return coord_t'(v);
  endfunction

  // Favor the extremes and zero now and then, otherwise any value.
  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0:       return COORD_LO;
      1:       return COORD_HI;
      2:       return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic void add_vertex(input int x, input int y);
    poly_x.push_back(clamp_coord(x));
    poly_y.push_back(clamp_coord(y));
  endfunction

  // Square loops around (cx, cy): each turn adds one to the winding count
  // when drawn counterclockwise, minus one when clockwise.
  function automatic void add_loops(input int cx, input int cy, input int r,
                                    input int corners, input bit ccw, input int jitter);
    int k;
    int c;
    int jx;
    int jy;
    for (k = 0; k < corners; k++) begin
      c  = ccw ? (k % 4) : (3 - (k % 4));
      jx = (jitter > 0) ? $urandom_range(2 * jitter) - jitter : 0;
      jy = (jitter > 0) ? $urandom_range(2 * jitter) - jitter : 0;
      case (c)
        0:       add_vertex(cx + r + jx, cy - r + jy);
        1:       add_vertex(cx + r + jx, cy + r + jy);
        2:       add_vertex(cx - r + jx, cy + r + jy);
        default: add_vertex(cx - r + jx, cy - r + jy);
      endcase
    end
  endfunction

  // Offer one vertex item and hold it until the block takes it.
  task automatic send_vertex(input coord_t qx, qy, vx, vy, input logic last);
    bit taken;
    bit no_idle;
    taken   = 1'b0;
    no_idle = ((tx_items % 700) >= 450) && ((tx_items % 700) < 650);
    while (!no_idle && ($urandom_range(99) < 25)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_query_x     <= qx;
    in_query_y     <= qy;
    in_vertex_x    <= vx;
    in_vertex_y    <= vy;
    in_last_vertex <= last;
    while (!taken) begin
      @(negedge clk);
      if (!in_stall) begin
        taken = 1'b1;
        sb.note_vertex(qx, qy, vx, vy, last);
      end
      @(posedge clk);
    end
    tx_items++;
  endtask

  // Stream the queued polygon; the query point only matters on the first
  // item, so later items carry noise there.
  task automatic send_polygon(input coord_t qx, qy);
    int     i;
    coord_t sx;
    coord_t sy;
    for (i = 0; i < poly_x.size(); i++) begin
      sx = (i == 0) ? qx : coord_t'($urandom);
      sy = (i == 0) ? qy : coord_t'($urandom);
      send_vertex(sx, sy, poly_x[i], poly_y[i], i == poly_x.size() - 1);
    end
    poly_x.delete();
    poly_y.delete();
  endtask

  initial begin : stimulus
    int     sent;
    int     size;
    int     roll;
    int     mode;
    int     spread;
    int     k;
    coord_t qx;
    coord_t qy;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_query_x     = '0;
    in_query_y     = '0;
    in_vertex_x    = '0;
    in_vertex_y    = '0;
    in_last_vertex = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Square of half-side 10 counterclockwise, clockwise, and with the point outside.
    add_loops(0, 0, 10, 4, 1'b1, 0);
    send_polygon('0, '0);
    add_loops(0, 0, 10, 4, 1'b0, 0);
    send_polygon('0, '0);
    add_loops(0, 0, 10, 4, 1'b1, 0);
    send_polygon(16'sd50, -16'sd3);

    // One vertex at the corner of the range: degenerate closing edge, flagged bad.
    add_vertex(32767, -32768);
    send_polygon(COORD_LO, COORD_HI);
    // Two vertices: too few, flagged bad.
    add_vertex(-32768, -32768);
    add_vertex(32767, 32767);
    send_polygon('0, '0);

    // Full-range triangles, point at the center and at corners of the range.
    add_vertex(-32768, -32768);
    add_vertex(32767, -32768);
    add_vertex(0, 32767);
    send_polygon('0, '0);
    add_vertex(-32768, -32768);
    add_vertex(32767, -32768);
    add_vertex(0, 32767);
    send_polygon(COORD_HI, COORD_HI);
    add_vertex(32767, 32767);
    add_vertex(-32768, 32767);
    add_vertex(-32768, -32768);
    send_polygon(COORD_LO, COORD_LO);

    // Point on an edge, on a vertex, and level with a vertex.
    add_vertex(0, 0);
    add_vertex(10, 0);
    add_vertex(0, 10);
    send_polygon(16'sd5, '0);
    add_vertex(0, 0);
    add_vertex(10, 0);
    add_vertex(0, 10);
    send_polygon('0, '0);
    add_vertex(0, 0);
    add_vertex(10, 0);
    add_vertex(0, 10);
    send_polygon(-16'sd5, 16'sd10);

    // Last vertex repeats the first.
    add_vertex(0, -5);
    add_vertex(5, 5);
    add_vertex(-5, 5);
    add_vertex(0, -5);
    send_polygon('0, '0);

    // Widest operands for the cross product.
    add_vertex(-32768, 32767);
    add_vertex(32767, -32768);
    add_vertex(32767, 32767);
    send_polygon(16'sd32766, -16'sd32767);

    // Largest legal polygon: 256 turns, winding number 256.
    add_loops(0, 0, 1000, MAX_VERTICES_DEF, 1'b1, 0);
    send_polygon('0, '0);
    // One vertex too many.
    add_loops(0, 0, 1000, MAX_VERTICES_DEF + 1, 1'b0, 0);
    send_polygon('0, '0);

    // Random polygons: mostly small, some degenerate, a few long ones.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 8) size = $urandom_range(2, 1);
      else if (roll < 78) size = $urandom_range(10, 3);
      else if (roll < 96) size = $urandom_range(40, 11);
      else size = $urandom_range(200, 41);
      qx   = pick_coord();
      qy   = pick_coord();
      mode = $urandom_range(3);
      case (mode)
        0: begin
          for (k = 0; k < size; k++) begin
            poly_x.push_back(pick_coord());
            poly_y.push_back(pick_coord());
          end
        end
        1: begin
          // Cluster around the point: many shared rows and zero cross products.
          spread = ($urandom_range(1)) ? 2 : 64;
          for (k = 0; k < size; k++)
            add_vertex(int'(qx) + $urandom_range(2 * spread) - spread,
                       int'(qy) + $urandom_range(2 * spread) - spread);
        end
        default: begin
          add_loops(int'(qx), int'(qy), $urandom_range(20000, 1), size,
                    $urandom_range(1), $urandom_range(8));
        end
      endcase
      send_polygon(qx, qy);
      sent += size;
    end

    // Drain: wait out every closed polygon, then a few cycles for strays.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d polygons (%0d flagged bad, longest %0d vertices) in %0d items.",
             sb.polygons, sb.bad_polygons, sb.longest, sb.vertex_items);
    $display("Input pushed back in %0d cycles; %0d results checked.",
             held_cycles, sb.results);
    if (sb.errors == 0) begin
      $display("point_in_polygon_winding: match");
    end else begin
      $display("point_in_polygon_winding: mismatch");
    end
    $finish;
  end

endmodule
